// ----- src/sublist_match_detector_assert.svh -----
// Assertion macros used by the checker of the sublist match detector.
`ifndef SUBLIST_MATCH_DETECTOR_ASSERT_SVH
`define SUBLIST_MATCH_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/smd_pkg.sv -----
`timescale 1ns / 1ps

package smd_pkg;

  // Width of the value field on the input channel.
  localparam int VALUE_W = 32;

  // Item kinds carried in the mode field.
  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_MAIN    = 1'b1;

  // One input item.
  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
    logic               last;
  } smd_in_t;

  // One result item.
  typedef struct packed {
    logic found;
    logic pattern_overflow;
  } smd_out_t;

endpackage

// ----- src/sublist_match_detector.sv -----
`timescale 1ns / 1ps
// A closing main word passes the input register, then its result is held in the result register.
// Throughput: one item per cycle; an input register feeds the parallel lane compare,
// whose outcome lands in the result register, so other items enter while a result waits;
// a closing main word holds in the input register until the result slot frees.
// Reset clears the pattern length, load and search state and the valid flags of both channel
// registers; the pattern words and payloads are not cleared and only written entries are compared.
module sublist_match_detector import smd_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int WORD_WIDTH  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  smd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output smd_out_t out_data
);

  logic     in_valid_r, in_valid_nxt;
  smd_in_t  in_item_r;
  logic     out_valid_r, out_valid_nxt;
  smd_out_t out_data_r;

  logic     out_free;
  logic     gives_result;
  logic     step;
  smd_out_t result;

  // Stage control: a closing main word moves on only when the result slot is free.
  assign out_free     = !out_valid_r || out_ready;
  assign gives_result = (in_item_r.mode == MODE_MAIN) && in_item_r.last;
  assign step         = in_valid_r && (!gives_result || out_free);
  assign in_ready     = !in_valid_r || step;

  assign in_valid_nxt  = (in_valid && in_ready) || (in_valid_r && !step);
  assign out_valid_nxt = (step && gives_result) || (out_valid_r && !out_ready);

  smd_match_lanes #(
    .PATTERN_MAX (PATTERN_MAX),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_lanes (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .result (result)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (step && gives_result) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/smd_match_lanes.sv -----
`timescale 1ns / 1ps

module smd_match_lanes import smd_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int WORD_WIDTH  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  smd_in_t  item,
  output smd_out_t result
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int CW = (WORD_WIDTH < VALUE_W) ? WORD_WIDTH : VALUE_W;

  // Pattern words, one register per compare lane.
  logic [CW-1:0]          pat_r [PATTERN_MAX];
  logic [LW-1:0]          len_r, len_nxt;
  logic                   loading_r, loading_nxt;
  logic [PATTERN_MAX-1:0] pmv_r, pmv_nxt;
  logic                   match_r, match_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [CW-1:0]          word;
  logic                   is_load;
  logic                   start;
  logic [LW-1:0]          len_base;
  logic                   room;
  logic                   wr_en;
  logic [PATTERN_MAX-1:0] pmv_upd;
  logic [PATTERN_MAX-1:0] lastpos;
  logic                   full_hit;

  assign word     = item.value[CW-1:0];
  assign is_load  = (item.mode == MODE_PATTERN);
  assign start    = is_load && !loading_r;
  assign len_base = start ? '0 : len_r;
  assign room     = (len_base < LW'(PATTERN_MAX));
  assign wr_en    = step && is_load && room;

  // Per-lane compare, prefix shift and pattern-word write.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_lane
    logic prev;
    if (i == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = pmv_r[i-1];
    end

    assign pmv_upd[i] = prev && (pat_r[i] == word) && (LW'(i) < len_r);
    assign lastpos[i] = (LW'(i + 1) == len_r);

    always_ff @(posedge clk) begin
      if (wr_en && (len_base == LW'(i))) begin
        pat_r[i] <= word;
      end
    end
  end

  // The full pattern matched on this word.
  assign full_hit = |(pmv_upd & lastpos);

  // Result for a closing main word.
  assign result.found            = (match_r || full_hit) && !ovf_r;
  assign result.pattern_overflow = ovf_r;

  // Next state for one item.
  always_comb begin
    len_nxt     = len_r;
    loading_nxt = loading_r;
    pmv_nxt     = pmv_r;
    match_nxt   = match_r;
    ovf_nxt     = ovf_r;
    priority if (is_load) begin
      if (start) begin
        ovf_nxt   = 1'b0;
        pmv_nxt   = '0;
        match_nxt = 1'b0;
      end
      if (room) begin
        len_nxt = len_base + LW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      loading_nxt = !item.last;
    end else begin
      loading_nxt = 1'b0;
      if (item.last) begin
        pmv_nxt   = '0;
        match_nxt = 1'b0;
      end else begin
        pmv_nxt   = pmv_upd;
        match_nxt = match_r || full_hit;
      end
    end
  end

  // Search and load state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      loading_r <= 1'b0;
      pmv_r     <= '0;
      match_r   <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (step) begin
      len_r     <= len_nxt;
      loading_r <= loading_nxt;
      pmv_r     <= pmv_nxt;
      match_r   <= match_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

// ----- src/smd_checker.sv -----
`timescale 1ns / 1ps
`include "sublist_match_detector_assert.svh"

module smd_checker import smd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input smd_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input smd_out_t out_data
);

  // A stalled input transfer holds its value.
  `SMD_ASSERT_NEXT(a_in_hold, clk, rst_n,
                   in_valid && !in_ready,
                   in_valid && $stable(in_data),
                   "input changed while stalled")

  // A stalled result holds its value.
  `SMD_ASSERT_NEXT(a_out_hold, clk, rst_n,
                   out_valid && !out_ready,
                   out_valid && $stable(out_data),
                   "result changed while stalled")

  // A truncated pattern never reports a match.
  `SMD_ASSERT_NOW(a_ovf_no_found, clk, rst_n,
                  out_valid,
                  !(out_data.found && out_data.pattern_overflow),
                  "found reported with overflow")

  // With no result waiting, the input side is always open.
  `SMD_ASSERT_NOW(a_ready_when_empty, clk, rst_n,
                  !out_valid,
                  in_ready,
                  "input stalled with empty result slot")

endmodule

bind sublist_match_detector smd_checker u_smd_checker (.*);
